>>> design/cbmq_pkg.sv
`timescale 1ns / 1ps

package cbmq_pkg;

	localparam int MAX_ITEMS      = 16;
	localparam int MAX_ITEM_BYTES = 8;

	localparam int QI_W       = 5;
	localparam int IB_W       = 4;
	localparam int POS_W      = 4;
	localparam int DATA_W     = 64;
	localparam int CNT_OUT_W  = 8;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 8;
	localparam int S_TDATA_W  = 72;
	localparam int M_TDATA_W  = 80;

	localparam logic [QI_W-1:0] QI_RESET = 5'd16;
	localparam logic [IB_W-1:0] IB_RESET = 4'd1;

	localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ITEMS = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ITEM_BYTES  = 8'd1;

	typedef enum logic [1:0] {
		REQ_WRITE_BYTE = 2'd0,
		REQ_WRITE_ITEM = 2'd1,
		REQ_READ_BYTE  = 2'd2,
		REQ_READ_ITEM  = 2'd3
	} req_t;

endpackage

>>> design/cbmq_ram.sv
`timescale 1ns / 1ps

module cbmq_ram #(
	parameter int DEPTH = 128,
	parameter int AW    = 7
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [7:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [7:0]    rdata
);

	logic [7:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> design/compacting_byte_message_queue.sv
`timescale 1ns / 1ps

// Byte message queue holding queue_items * item_bytes bytes in a single byte RAM with one
// write and one registered read port. A small sequencer moves one byte per cycle through
// that port: a request moves its n bytes (n = 1 for a byte, item_bytes for an item), and a
// read with delete that leaves k > 0 bytes behind the removed entry then copies each later
// byte down one at a time through the same RAM port to compact the store. An error skips
// the RAM and goes straight to the final step. s_tready is low while a request is in
// progress; one finished result may wait in the output register while the next request is
// taken, and that next request then holds in its last step until the waiting result is
// taken. Configuration writes are taken only between requests, and writes to either of the
// two registers clear the byte count. The store needs no clearing pass after reset: only
// bytes that were written are ever read.
module compacting_byte_message_queue #(
	parameter int MAX_ITEMS      = cbmq_pkg::MAX_ITEMS,
	parameter int MAX_ITEM_BYTES = cbmq_pkg::MAX_ITEM_BYTES
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// position[3:0], delete_after_read[4], write_data[68:5], zero[71:69]
	input  logic [cbmq_pkg::S_TDATA_W-1:0]   s_tdata,
	// req_type[1:0]
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// read_data[63:0], bytes_held[71:64], bytes_free[79:72]
	output logic [cbmq_pkg::M_TDATA_W-1:0]   m_tdata,
	// ok[0]
	output logic                             m_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cbmq_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbmq_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int STORE_BYTES = MAX_ITEMS * MAX_ITEM_BYTES;
	localparam int CW  = $clog2(STORE_BYTES + 1);
	localparam int AW  = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
	localparam int PW  = ((CW > 8) ? CW : 8) + 1;
	localparam int IW  = (MAX_ITEM_BYTES > 1) ? $clog2(MAX_ITEM_BYTES) : 1;
	localparam int QW  = cbmq_pkg::QI_W;
	localparam int IBW = cbmq_pkg::IB_W;
	localparam int DW  = cbmq_pkg::DATA_W;
	localparam int OW  = cbmq_pkg::CNT_OUT_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_SHIFT,
		ST_DONE
	} state_t;

	state_t              state_q;
	logic [QW-1:0]       qi_q;
	logic [IBW-1:0]      ib_q;
	logic [CW-1:0]       count_q;
	logic                m_tvalid_q;
	logic                rd_v_s1;
	logic                sh_v_s1;
	logic [IW-1:0]       rd_idx_s1;

	logic [IBW-1:0]      len_q;
	logic [IW-1:0]       idx_q;
	logic [PW-1:0]       ptr_q;
	logic [PW-1:0]       dst_q;
	logic [PW-1:0]       end_q;
	logic                del_q;
	logic [DW-1:0]       wdata_q;
	logic                ok_q;
	logic [DW-1:0]       rdata_q;
	logic                m_ok_q;
	logic [DW-1:0]       m_rdata_q;
	logic [OW-1:0]       m_held_q;
	logic [OW-1:0]       m_free_q;

	cbmq_pkg::req_t      s_req;
	logic [3:0]          s_pos;
	logic                s_del;
	logic [DW-1:0]       s_wdata;

	logic                cfg_ok;
	logic [PW-1:0]       cap;
	logic [PW-1:0]       cnt_x;
	logic [IBW-1:0]      len_sel;
	logic [PW-1:0]       len_x;
	logic [PW-1:0]       off_x;
	logic [PW-1:0]       end_x;
	logic                is_write;
	logic                req_ok;

	logic                in_acc;
	logic                cfg_acc;
	logic                idx_last;
	logic [PW-1:0]       ptr_inc;
	logic                load_out;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [7:0]          ram_wdata;
	logic [AW-1:0]       ram_raddr;
	logic [7:0]          ram_rdata;

	assign s_req   = cbmq_pkg::req_t'(s_tuser);
	assign s_pos   = s_tdata[3:0];
	assign s_del   = s_tdata[4];
	assign s_wdata = s_tdata[68:5];

	assign s_tready  = (state_q == ST_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == ST_IDLE);
	assign in_acc    = s_tvalid && s_tready;
	assign cfg_acc   = cfg_valid && cfg_ready;

	always_comb begin
		cfg_ok = (qi_q != '0) && (32'(qi_q) <= MAX_ITEMS) &&
		         (ib_q != '0) && (32'(ib_q) <= MAX_ITEM_BYTES);
		cap    = cfg_ok ? (PW'(qi_q) * PW'(ib_q)) : '0;
		cnt_x  = PW'(count_q);
		len_sel = ((s_req == cbmq_pkg::REQ_WRITE_BYTE) || (s_req == cbmq_pkg::REQ_READ_BYTE)) ?
		          IBW'(1) : ib_q;
		len_x  = PW'(len_sel);
		off_x  = PW'(s_pos) * len_x;
		end_x  = off_x + len_x;
		is_write = (s_req == cbmq_pkg::REQ_WRITE_BYTE) || (s_req == cbmq_pkg::REQ_WRITE_ITEM);
		unique case (s_req)
			cbmq_pkg::REQ_WRITE_BYTE: req_ok = (ib_q == IBW'(1)) && (cnt_x < cap);
			cbmq_pkg::REQ_WRITE_ITEM: req_ok = ((cnt_x + len_x) <= cap);
			cbmq_pkg::REQ_READ_BYTE:  req_ok = (ib_q == IBW'(1)) && (end_x <= cnt_x);
			cbmq_pkg::REQ_READ_ITEM:  req_ok = (end_x <= cnt_x);
			default:                  req_ok = 1'b0;
		endcase
		req_ok = req_ok && (cap != '0);
	end

	assign idx_last = (IBW'(idx_q) == (len_q - IBW'(1)));
	assign ptr_inc  = ptr_q + PW'(1);
	assign load_out = (state_q == ST_DONE) && !rd_v_s1 && (!m_tvalid_q || m_tready);

	assign ram_we    = (state_q == ST_WRITE) || sh_v_s1;
	assign ram_waddr = sh_v_s1 ? dst_q[AW-1:0] : ptr_q[AW-1:0];
	assign ram_wdata = sh_v_s1 ? ram_rdata : wdata_q[7:0];
	assign ram_raddr = ptr_q[AW-1:0];

	cbmq_ram #(
		.DEPTH (STORE_BYTES),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			qi_q       <= cbmq_pkg::QI_RESET;
			ib_q       <= cbmq_pkg::IB_RESET;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
			rd_v_s1    <= 1'b0;
			sh_v_s1    <= 1'b0;
		end else begin
			rd_v_s1 <= (state_q == ST_READ);
			sh_v_s1 <= (state_q == ST_SHIFT);
			if (load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						priority if (cfg_index == cbmq_pkg::REG_QUEUE_ITEMS) begin
							qi_q    <= cfg_data[QW-1:0];
							count_q <= '0;
						end else if (cfg_index == cbmq_pkg::REG_ITEM_BYTES) begin
							ib_q    <= cfg_data[IBW-1:0];
							count_q <= '0;
						end else begin
							count_q <= count_q;
						end
					end else if (in_acc) begin
						if (!req_ok) begin
							state_q <= ST_DONE;
						end else if (is_write) begin
							state_q <= ST_WRITE;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				ST_WRITE: begin
					if (idx_last) begin
						count_q <= count_q + CW'(len_q);
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					if (idx_last) begin
						if (!del_q) begin
							state_q <= ST_DONE;
						end else if (end_q < PW'(count_q)) begin
							state_q <= ST_SHIFT;
						end else begin
							count_q <= count_q - CW'(len_q);
							state_q <= ST_DONE;
						end
					end
				end
				ST_SHIFT: begin
					if (ptr_inc == PW'(count_q)) begin
						count_q <= count_q - CW'(len_q);
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (load_out) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (rd_v_s1) begin
			rdata_q[8*rd_idx_s1 +: 8] <= ram_rdata;
		end
		if (sh_v_s1) begin
			dst_q <= dst_q + PW'(1);
		end
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					rdata_q <= '0;
					len_q   <= len_sel;
					idx_q   <= '0;
					del_q   <= s_del;
					wdata_q <= s_wdata;
					end_q   <= end_x;
					dst_q   <= off_x;
					ok_q    <= req_ok;
					ptr_q   <= is_write ? cnt_x : off_x;
				end
			end
			ST_WRITE: begin
				wdata_q <= wdata_q >> 8;
				ptr_q   <= ptr_inc;
				idx_q   <= idx_q + IW'(1);
			end
			ST_READ: begin
				ptr_q <= idx_last ? end_q : ptr_inc;
				idx_q <= idx_q + IW'(1);
			end
			ST_SHIFT: begin
				ptr_q <= ptr_inc;
			end
			ST_DONE: begin
				if (load_out) begin
					m_ok_q    <= ok_q;
					m_rdata_q <= rdata_q;
					m_held_q  <= OW'(count_q);
					m_free_q  <= OW'(cap - PW'(count_q));
				end
			end
			default: ptr_q <= ptr_q;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_free_q, m_held_q, m_rdata_q};
	assign m_tuser  = m_ok_q;

endmodule

>>> design/cbmq_checker.sv
`timescale 1ns / 1ps

module cbmq_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [cbmq_pkg::M_TDATA_W-1:0]   m_tdata,
	input logic                             m_tuser,
	input logic                             cfg_ready
);

	// a request in progress blocks both new requests and configuration
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready && !cfg_ready)
		else $error("request accepted but block still ready next cycle");

	a_error_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[63:0] == 64'd0)
		else $error("error result carries nonzero read data");

	// a new result appears exactly when the sequencer returns to idle
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> cfg_ready)
		else $error("result presented while request still in progress");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result transaction changed or dropped");

endmodule

bind compacting_byte_message_queue cbmq_checker u_cbmq_checker (.*);

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int STORE_BYTES       = cbmq_pkg::MAX_ITEMS * cbmq_pkg::MAX_ITEM_BYTES;
	localparam int DRAIN_CYCLES      = 160;
	localparam int ITEMS_PER_SETTING = 64;
	localparam int MAX_REPORTS       = 40;

	localparam logic [cbmq_pkg::CFG_IDX_W-1:0] REG_UNUSED_FIRST = 8'd2;
	localparam logic [cbmq_pkg::CFG_IDX_W-1:0] REG_UNUSED_LAST  = 8'hff;

	typedef struct packed {
		logic        ok;
		logic [63:0] rdata;
		logic [7:0]  held;
		logic [7:0]  free;
	} reply_t;

	logic                              clk = 1'b0;
	logic                              arst_n = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [cbmq_pkg::S_TDATA_W-1:0]    s_tdata = '0;
	logic [1:0]                        s_tuser = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [cbmq_pkg::M_TDATA_W-1:0]    m_tdata;
	logic                              m_tuser;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [cbmq_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
	logic [cbmq_pkg::CFG_DATA_W-1:0]   cfg_data = '0;

	// queue mirror
	logic [7:0] mirror_bytes [0:STORE_BYTES-1];
	int         mirror_count = 0;
	int         mirror_items = 16;
	int         mirror_item_bytes = 1;

	reply_t pending_replies [$];
	int     err_count = 0;
	int     send_idle_pct = 0;
	int     stall_pct = 0;
	int     hold_off_cycles = 0;

	compacting_byte_message_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic int queue_capacity();
		if (mirror_items >= 1 && mirror_items <= cbmq_pkg::MAX_ITEMS &&
				mirror_item_bytes >= 1 && mirror_item_bytes <= cbmq_pkg::MAX_ITEM_BYTES) begin
			return mirror_items * mirror_item_bytes;
		end
		return 0;
	endfunction

	function automatic void apply_reg(logic [cbmq_pkg::CFG_IDX_W-1:0] idx,
			logic [cbmq_pkg::CFG_DATA_W-1:0] data);
		if (idx == cbmq_pkg::REG_QUEUE_ITEMS) begin
			mirror_items = int'(data[4:0]);
			mirror_count = 0;
		end else if (idx == cbmq_pkg::REG_ITEM_BYTES) begin
			mirror_item_bytes = int'(data[3:0]);
			mirror_count = 0;
		end
	endfunction

	function automatic reply_t predict_reply(cbmq_pkg::req_t req, logic [3:0] pos, logic del,
			logic [63:0] wdata);
		reply_t r;
		int cap;
		int len;
		int off;
		cap = queue_capacity();
		r = '0;
		if (cap != 0) begin
			case (req)
			cbmq_pkg::REQ_WRITE_BYTE: begin
				if (mirror_item_bytes == 1 && mirror_count < cap) begin
					mirror_bytes[mirror_count] = wdata[7:0];
					mirror_count++;
					r.ok = 1'b1;
				end
			end
			cbmq_pkg::REQ_WRITE_ITEM: begin
				if (mirror_count + mirror_item_bytes <= cap) begin
					for (int i = 0; i < mirror_item_bytes; i++)
						mirror_bytes[mirror_count + i] = wdata[8*i +: 8];
					mirror_count += mirror_item_bytes;
					r.ok = 1'b1;
				end
			end
			default: begin
				len = (req == cbmq_pkg::REQ_READ_BYTE) ? 1 : mirror_item_bytes;
				off = int'(pos) * len;
				if ((req == cbmq_pkg::REQ_READ_ITEM || mirror_item_bytes == 1) &&
						off + len <= mirror_count) begin
					for (int i = 0; i < len; i++)
						r.rdata[8*i +: 8] = mirror_bytes[off + i];
					if (del) begin
						for (int i = off; i + len < mirror_count; i++)
							mirror_bytes[i] = mirror_bytes[i + len];
						mirror_count -= len;
					end
					r.ok = 1'b1;
				end
			end
			endcase
		end
		r.held = 8'(mirror_count);
		r.free = 8'(cap - mirror_count);
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		if (err_count < MAX_REPORTS)
			$display("%0t ERROR %s: got %h want %h", $realtime, what, got, want);
		err_count++;
	endtask

	// result checker
	initial begin
		reply_t want;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_replies.size() == 0) begin
					report_mismatch("reply with nothing pending", m_tdata[63:0], '0);
				end else begin
					want = pending_replies.pop_front();
					if (m_tuser !== want.ok)
						report_mismatch("ok", 64'(m_tuser), 64'(want.ok));
					if (m_tdata[63:0] !== want.rdata)
						report_mismatch("read_data", m_tdata[63:0], want.rdata);
					if (m_tdata[71:64] !== want.held)
						report_mismatch("bytes_held", 64'(m_tdata[71:64]), 64'(want.held));
					if (m_tdata[79:72] !== want.free)
						report_mismatch("bytes_free", 64'(m_tdata[79:72]), 64'(want.free));
				end
			end
		end
	end

	// receiver pacing and long hold-off
	initial begin
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				m_tready <= 1'b0;
				hold_off_cycles--;
			end else begin
				m_tready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	task automatic send_req(cbmq_pkg::req_t req, logic [3:0] pos, logic del,
			logic [63:0] wdata);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {3'b000, wdata, del, pos};
		do @(posedge clk); while (!s_tready);
		pending_replies.push_back(predict_reply(req, pos, del, wdata));
	endtask

	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [cbmq_pkg::CFG_IDX_W-1:0] idx,
			logic [cbmq_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, data);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper data bits are don't-care for both registers
	task automatic set_geometry(int qi, int ib);
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, {3'($urandom), 5'(qi)});
		write_reg(cbmq_pkg::REG_ITEM_BYTES, {4'($urandom), 4'(ib)});
	endtask

	task automatic send_random_req();
		int cap;
		int ib;
		int held_items;
		bit do_write;
		cbmq_pkg::req_t req;
		logic [3:0] pos;
		logic del;
		logic [63:0] wdata;
		cap = queue_capacity();
		ib = mirror_item_bytes;
		wdata = {$urandom, $urandom};
		del = 1'($urandom_range(1));
		pos = 4'($urandom_range(15));
		req = cbmq_pkg::req_t'($urandom_range(3));
		if (cap != 0 && $urandom_range(99) >= 6) begin
			held_items = mirror_count / ib;
			if (mirror_count == 0)
				do_write = 1'b1;
			else if (mirror_count + ib > cap)
				do_write = ($urandom_range(9) == 0);
			else
				do_write = 1'($urandom_range(1));
			if (do_write) begin
				req = (ib == 1 && $urandom_range(1)) ? cbmq_pkg::REQ_WRITE_BYTE :
				      cbmq_pkg::REQ_WRITE_ITEM;
			end else begin
				req = (ib == 1 && $urandom_range(1)) ? cbmq_pkg::REQ_READ_BYTE :
				      cbmq_pkg::REQ_READ_ITEM;
				pos = (held_items > 0) ? 4'($urandom_range(held_items - 1)) : 4'd0;
				del = ($urandom_range(3) != 0);
			end
		end
		send_req(req, pos, del, wdata);
	endtask

	task automatic test_byte_mode();
		send_req(cbmq_pkg::REQ_READ_BYTE, 4'd0, 1'b0, '0);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd0, 1'b1, '0);
		send_req(cbmq_pkg::REQ_WRITE_BYTE, 4'd0, 1'b0, 64'h5a5a_5a5a_5a5a_5aa5);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd15, 1'b1, '1);
		send_req(cbmq_pkg::REQ_WRITE_BYTE, 4'd0, 1'b0, 64'h0);
		send_req(cbmq_pkg::REQ_READ_BYTE, 4'd1, 1'b0, '1);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd0, 1'b1, '0);
		send_req(cbmq_pkg::REQ_READ_BYTE, 4'd2, 1'b0, '0);
		send_req(cbmq_pkg::REQ_READ_BYTE, 4'd15, 1'b1, '0);
		wait_idle();
	endtask

	task automatic test_item_mode();
		set_geometry(2, 8);
		send_req(cbmq_pkg::REQ_WRITE_BYTE, 4'd0, 1'b0, 64'h11);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, '1);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, 64'h0123_4567_89ab_cdef);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, 64'hdead_beef_cafe_f00d);
		send_req(cbmq_pkg::REQ_READ_BYTE, 4'd0, 1'b0, '0);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd1, 1'b0, '0);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd0, 1'b1, '0);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd1, 1'b0, '0);
		wait_idle();
	endtask

	task automatic test_bad_geometry();
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, 8'h00);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, '1);
		wait_idle();
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, 8'd17);
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd0, 1'b1, '0);
		wait_idle();
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, 8'hff);
		write_reg(cbmq_pkg::REG_ITEM_BYTES, 8'h01);
		send_req(cbmq_pkg::REQ_WRITE_BYTE, 4'd0, 1'b0, '1);
		wait_idle();
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, 8'd16);
		write_reg(cbmq_pkg::REG_ITEM_BYTES, 8'h00);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, '1);
		wait_idle();
		write_reg(cbmq_pkg::REG_ITEM_BYTES, 8'h09);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, '1);
		wait_idle();
		write_reg(cbmq_pkg::REG_ITEM_BYTES, 8'hff);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, '1);
		wait_idle();
	endtask

	task automatic test_unused_register();
		write_reg(cbmq_pkg::REG_QUEUE_ITEMS, 8'hf0);
		write_reg(cbmq_pkg::REG_ITEM_BYTES, 8'h08);
		send_req(cbmq_pkg::REQ_WRITE_ITEM, 4'd0, 1'b0, 64'h8877_6655_4433_2211);
		wait_idle();
		write_reg(REG_UNUSED_FIRST, 8'($urandom));
		write_reg(REG_UNUSED_LAST, 8'($urandom));
		send_req(cbmq_pkg::REQ_READ_ITEM, 4'd0, 1'b1, '0);
		wait_idle();
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure_fill();
		set_geometry(16, 1);
		send_idle_pct = 0;
		stall_pct = 0;
		hold_off_cycles = 400;
		repeat (40) send_random_req();
		wait_idle();
	endtask

	task automatic test_random_traffic();
		for (int p = 0; p < 4; p++) begin
			case (p)
			0: begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				send_idle_pct = 87;
				stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				stall_pct = 87;
			end
			default: begin
				send_idle_pct = 20;
				stall_pct = 20;
			end
			endcase
			for (int g = 0; g < 5; g++) begin
				wait_idle();
				case (g)
				0: set_geometry(16, 1);
				1: set_geometry(1, 1);
				2: set_geometry(16, 8);
				3: set_geometry(1, 8);
				default: set_geometry($urandom_range(16, 1), $urandom_range(8, 1));
				endcase
				repeat (ITEMS_PER_SETTING) send_random_req();
			end
		end
		wait_idle();
		send_idle_pct = 0;
		stall_pct = 0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_byte_mode();
		test_item_mode();
		test_bad_geometry();
		test_unused_register();
		test_backpressure_fill();
		test_random_traffic();
		wait_idle();
		if (err_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#30_000_000;
		$display("timeout with %0d replies pending", pending_replies.size());
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
